### rtl/vrt_pkg.sv
// Shared types and constants of the voxel ray traversal block.
package vrt_pkg;

   localparam int POS_W = 15;   // ray start and end coordinates
   localparam int IDX_W = 5;    // voxel and hit cell indices
   localparam int NRM_W = 2;    // signed face normal components

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_STEP,
      ST_READ,
      ST_EVAL,
      ST_FIN
   } vrt_state_type;

   typedef struct packed {
      logic clear_en;
      logic load;
      logic do_mul;
      logic do_step;
      logic do_read;
      logic set_hit;
      logic fin_load;
   } vrt_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic at_end;
      logic at_limit;
      logic out_grid;
      logic solid;
   } vrt_status_type;

endpackage

### rtl/vrt_ctrl.sv
// Sequencer that steps the ray walk through multiply, step, read and test.
module vrt_ctrl
   import vrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_mode,
   output logic           req_ready,
   input  logic           rsp_free,
   input  vrt_status_type status,
   output vrt_cmd_type    cmd
);

   vrt_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = req_mode ? ST_CHECK : ST_FIN;
         end
         ST_CHECK: begin
            if (status.at_end || status.at_limit) state_in = ST_FIN;
            else state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_STEP;
         ST_STEP: state_in = ST_READ;
         ST_READ: begin
            if (status.out_grid) state_in = ST_FIN;
            else state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.solid) state_in = ST_FIN;
            else state_in = ST_CHECK;
         end
         ST_FIN: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.clear_en = (state_ff == ST_CLEAR);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.do_mul   = (state_ff == ST_MUL);
      cmd.do_step  = (state_ff == ST_STEP);
      cmd.do_read  = (state_ff == ST_READ) && !status.out_grid;
      cmd.set_hit  = (state_ff == ST_EVAL) && status.solid;
      cmd.fin_load = (state_ff == ST_FIN) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_step_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |=> (state_ff == ST_READ)) else $error("step not followed by read");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK || state_ff == ST_FIN))
      else $error("accepted item did not start");
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !rsp_free) |=> (state_ff == ST_FIN))
      else $error("result dropped while output busy");
`endif

endmodule

### rtl/vrt_dp.sv
// Ray walk datapath: occupancy memory, crossing times, products and cell position.
module vrt_dp
   import vrt_pkg::*;
#(
   parameter int GRID_SIDE = 32,
   parameter int FRAC_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vrt_cmd_type             cmd,
   input  logic                    req_mode,
   input  logic [IDX_W-1:0]        req_voxel_x,
   input  logic [IDX_W-1:0]        req_voxel_y,
   input  logic [IDX_W-1:0]        req_voxel_z,
   input  logic                    req_solid,
   input  logic [POS_W-1:0]        req_start_x,
   input  logic [POS_W-1:0]        req_start_y,
   input  logic [POS_W-1:0]        req_start_z,
   input  logic [POS_W-1:0]        req_end_x,
   input  logic [POS_W-1:0]        req_end_y,
   input  logic [POS_W-1:0]        req_end_z,
   output vrt_status_type          status,
   output logic                    res_hit,
   output logic [IDX_W-1:0]        res_x,
   output logic [IDX_W-1:0]        res_y,
   output logic [IDX_W-1:0]        res_z,
   output logic signed [NRM_W-1:0] res_nx,
   output logic signed [NRM_W-1:0] res_ny,
   output logic signed [NRM_W-1:0] res_nz
);

   localparam int CELLS      = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int AW         = $clog2(CELLS);
   localparam int IW         = $clog2(GRID_SIDE);
   localparam int CW         = (FRAC_BITS >= 14) ? 3 : 17 - FRAC_BITS;
   localparam int STEP_LIMIT = 3 * GRID_SIDE;
   localparam int SW         = $clog2(STEP_LIMIT + 1);
   localparam int NW         = $clog2(STEP_LIMIT + 1) + FRAC_BITS + 1;
   localparam int PRW        = NW + POS_W;
   localparam int unsigned ONE   = 32'd1 << FRAC_BITS;
   localparam int unsigned FMASK = ONE - 32'd1;

   logic                 grid_mem [CELLS];
   logic                 rd_ff;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic signed [CW-1:0] cur_ff [3], cur_in [3];
   logic signed [CW-1:0] last_ff [3], last_in [3];
   logic [2:0]           neg_ff, neg_in;
   logic [POS_W-1:0]     adir_ff [3], adir_in [3];
   logic [NW-1:0]        num_ff [3], num_in [3];
   logic [PRW-1:0]       prod_ff [6], prod_in [6];
   logic [SW-1:0]        steps_ff, steps_in;
   logic [2:0]           axis_ff, axis_in;
   logic                 hit_ff, hit_in;

   logic [POS_W-1:0] pos_s [3];
   logic [POS_W-1:0] pos_e [3];
   logic [2:0]       nz;
   logic             lt01, lt02, lt12;
   logic [2:0]       sel;
   logic [2:0]       off_axis;
   logic             wr_en, wr_data, wr_inrange;
   logic [AW-1:0]    wr_addr, rd_addr;

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] x, input logic [IW-1:0] y,
                                               input logic [IW-1:0] z);
      return AW'(32'(z) * 32'(GRID_SIDE * GRID_SIDE) + 32'(y) * 32'(GRID_SIDE) + 32'(x));
   endfunction

   assign pos_s[0] = req_start_x;
   assign pos_s[1] = req_start_y;
   assign pos_s[2] = req_start_z;
   assign pos_e[0] = req_end_x;
   assign pos_e[1] = req_end_y;
   assign pos_e[2] = req_end_z;

   // Strict time order by cross multiplication; a still axis never wins.
   always_comb begin
      for (int k = 0; k < 3; k++) nz[k] = (adir_ff[k] != '0);
      lt01 = nz[0] && (!nz[1] || prod_ff[0] < prod_ff[1]);
      lt02 = nz[0] && (!nz[2] || prod_ff[2] < prod_ff[3]);
      lt12 = nz[1] && (!nz[2] || prod_ff[4] < prod_ff[5]);
      sel[0] = lt01 && lt02;
      sel[1] = !lt01 && lt12;
      sel[2] = lt01 ? !lt02 : !lt12;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off_axis[k] = (int'(cur_ff[k]) < 0) || (int'(cur_ff[k]) >= GRID_SIDE);
      end
      status.clr_last = (clr_cnt_ff == AW'(CELLS - 1));
      status.at_end   = (cur_ff[0] == last_ff[0]) && (cur_ff[1] == last_ff[1])
                        && (cur_ff[2] == last_ff[2]);
      status.at_limit = (steps_ff == SW'(STEP_LIMIT));
      status.out_grid = |off_axis;
      status.solid    = rd_ff;
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      cur_in     = cur_ff;
      last_in    = last_ff;
      neg_in     = neg_ff;
      adir_in    = adir_ff;
      num_in     = num_ff;
      steps_in   = steps_ff;
      axis_in    = axis_ff;
      hit_in     = hit_ff;
      if (cmd.clear_en) clr_cnt_in = clr_cnt_ff + AW'(1);
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            cur_in[k]  = CW'(pos_s[k] >> FRAC_BITS);
            last_in[k] = CW'(pos_e[k] >> FRAC_BITS);
            if (pos_e[k] >= pos_s[k]) begin
               neg_in[k]  = 1'b0;
               adir_in[k] = pos_e[k] - pos_s[k];
               num_in[k]  = NW'(ONE - (32'(pos_s[k]) & FMASK));
            end else begin
               neg_in[k]  = 1'b1;
               adir_in[k] = pos_s[k] - pos_e[k];
               num_in[k]  = NW'(32'(pos_s[k]) & FMASK);
            end
         end
         steps_in = '0;
         axis_in  = '0;
         hit_in   = 1'b0;
      end
      if (cmd.do_step) begin
         for (int k = 0; k < 3; k++) begin
            if (sel[k]) begin
               num_in[k] = num_ff[k] + NW'(ONE);
               cur_in[k] = neg_ff[k] ? cur_ff[k] - CW'(1) : cur_ff[k] + CW'(1);
            end
         end
         steps_in = steps_ff + SW'(1);
         axis_in  = sel;
      end
      if (cmd.set_hit) hit_in = 1'b1;
   end

   always_comb begin
      prod_in[0] = PRW'(num_ff[0]) * PRW'(adir_ff[1]);
      prod_in[1] = PRW'(num_ff[1]) * PRW'(adir_ff[0]);
      prod_in[2] = PRW'(num_ff[0]) * PRW'(adir_ff[2]);
      prod_in[3] = PRW'(num_ff[2]) * PRW'(adir_ff[0]);
      prod_in[4] = PRW'(num_ff[1]) * PRW'(adir_ff[2]);
      prod_in[5] = PRW'(num_ff[2]) * PRW'(adir_ff[1]);
   end

   always_comb begin
      wr_inrange = (32'(req_voxel_x) < GRID_SIDE) && (32'(req_voxel_y) < GRID_SIDE)
                   && (32'(req_voxel_z) < GRID_SIDE);
      wr_en   = cmd.clear_en || (cmd.load && !req_mode && wr_inrange);
      wr_data = cmd.clear_en ? 1'b0 : req_solid;
      wr_addr = cmd.clear_en ? clr_cnt_ff
                : cell_addr(IW'(req_voxel_x), IW'(req_voxel_y), IW'(req_voxel_z));
      rd_addr = cell_addr(IW'(cur_ff[0]), IW'(cur_ff[1]), IW'(cur_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (wr_en) grid_mem[wr_addr] <= wr_data;
      if (cmd.do_read) rd_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         steps_ff   <= '0;
         hit_ff     <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         steps_ff   <= steps_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      last_ff <= last_in;
      neg_ff  <= neg_in;
      adir_ff <= adir_in;
      num_ff  <= num_in;
      axis_ff <= axis_in;
      if (cmd.do_mul) prod_ff <= prod_in;
   end

   // The entered face faces against the direction of the last step.
   always_comb begin
      res_hit = hit_ff;
      res_x   = hit_ff ? IDX_W'(cur_ff[0]) : '0;
      res_y   = hit_ff ? IDX_W'(cur_ff[1]) : '0;
      res_z   = hit_ff ? IDX_W'(cur_ff[2]) : '0;
      res_nx  = (hit_ff && axis_ff[0]) ? (neg_ff[0] ? NRM_W'(1) : NRM_W'(-1)) : '0;
      res_ny  = (hit_ff && axis_ff[1]) ? (neg_ff[1] ? NRM_W'(1) : NRM_W'(-1)) : '0;
      res_nz  = (hit_ff && axis_ff[2]) ? (neg_ff[2] ? NRM_W'(1) : NRM_W'(-1)) : '0;
   end

`ifndef SYNTHESIS
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(STEP_LIMIT)) else $error("step count beyond bound");
   a_hit_in_grid: assert property (@(posedge clock) disable iff (reset)
      cmd.set_hit |-> !status.out_grid) else $error("hit outside grid");
   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.do_step |=> (steps_ff == $past(steps_ff) + SW'(1)) && $onehot(axis_ff))
      else $error("step not counted");
`endif

endmodule

### rtl/voxel_ray_traversal.sv
// Voxel ray traversal top level: controller, datapath and result register.
// After reset the block clears its GRID_SIDE^3 occupancy memory one cell per
// cycle and takes no item until that is done. A write item goes from idle
// straight to the finish state. A ray item walks each cell stepped through
// end test, product, step, memory read and occupancy test; a walk ends at the
// end test on the end cell or the step limit of 3*GRID_SIDE, at the memory
// read when it leaves the grid, and at the occupancy test on a solid cell.
// The occupancy memory read and the six registered time products each have a
// state of their own. A result that waits on rsp_ready holds the block in its
// finish state. One item is in work at a time; its result sits in an output register while the next item is accepted.
module voxel_ray_traversal
   import vrt_pkg::*;
#(
   parameter int GRID_SIDE = 32,
   parameter int FRAC_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [IDX_W-1:0]        req_voxel_x,
   input  logic [IDX_W-1:0]        req_voxel_y,
   input  logic [IDX_W-1:0]        req_voxel_z,
   input  logic                    req_solid,
   input  logic [POS_W-1:0]        req_start_x,
   input  logic [POS_W-1:0]        req_start_y,
   input  logic [POS_W-1:0]        req_start_z,
   input  logic [POS_W-1:0]        req_end_x,
   input  logic [POS_W-1:0]        req_end_y,
   input  logic [POS_W-1:0]        req_end_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_hit,
   output logic [IDX_W-1:0]        rsp_hit_x,
   output logic [IDX_W-1:0]        rsp_hit_y,
   output logic [IDX_W-1:0]        rsp_hit_z,
   output logic signed [NRM_W-1:0] rsp_normal_x,
   output logic signed [NRM_W-1:0] rsp_normal_y,
   output logic signed [NRM_W-1:0] rsp_normal_z
);

   vrt_cmd_type    cmd;
   vrt_status_type status;
   logic           rsp_free;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           res_hit;
   logic [IDX_W-1:0] res_x, res_y, res_z;
   logic signed [NRM_W-1:0] res_nx, res_ny, res_nz;
   logic           hit_ff;
   logic [IDX_W-1:0] hit_x_ff, hit_y_ff, hit_z_ff;
   logic signed [NRM_W-1:0] nx_ff, ny_ff, nz_ff;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd)
   );

   vrt_dp #(
      .GRID_SIDE (GRID_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_mode    (req_mode),
      .req_voxel_x (req_voxel_x),
      .req_voxel_y (req_voxel_y),
      .req_voxel_z (req_voxel_z),
      .req_solid   (req_solid),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_start_z (req_start_z),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_end_z   (req_end_z),
      .status      (status),
      .res_hit     (res_hit),
      .res_x       (res_x),
      .res_y       (res_y),
      .res_z       (res_z),
      .res_nx      (res_nx),
      .res_ny      (res_ny),
      .res_nz      (res_nz)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.fin_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_load) begin
         hit_ff   <= res_hit;
         hit_x_ff <= res_x;
         hit_y_ff <= res_y;
         hit_z_ff <= res_z;
         nx_ff    <= res_nx;
         ny_ff    <= res_ny;
         nz_ff    <= res_nz;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_hit_x    = hit_x_ff;
   assign rsp_hit_y    = hit_y_ff;
   assign rsp_hit_z    = hit_z_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;
   assign rsp_normal_z = nz_ff;

endmodule

### test/voxel_ray_checker.sv
// Checker for the voxel ray traversal block: mirrors the grid, predicts and compares results.
module voxel_ray_checker
   import vrt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_mode,
   input  logic [IDX_W-1:0]        req_voxel_x,
   input  logic [IDX_W-1:0]        req_voxel_y,
   input  logic [IDX_W-1:0]        req_voxel_z,
   input  logic                    req_solid,
   input  logic [POS_W-1:0]        req_start_x,
   input  logic [POS_W-1:0]        req_start_y,
   input  logic [POS_W-1:0]        req_start_z,
   input  logic [POS_W-1:0]        req_end_x,
   input  logic [POS_W-1:0]        req_end_y,
   input  logic [POS_W-1:0]        req_end_z,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_hit,
   input  logic [IDX_W-1:0]        rsp_hit_x,
   input  logic [IDX_W-1:0]        rsp_hit_y,
   input  logic [IDX_W-1:0]        rsp_hit_z,
   input  logic signed [NRM_W-1:0] rsp_normal_x,
   input  logic signed [NRM_W-1:0] rsp_normal_y,
   input  logic signed [NRM_W-1:0] rsp_normal_z,
   output int                      error_count,
   output int                      pending_count,
   output int                      hit_count,
   output int                      ray_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE = 32;
   localparam int FRAC = 10;
   localparam int MAX_STEPS = 3 * SIDE;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] x, y, z;
      logic [NRM_W-1:0] nx, ny, nz;
   } cast_result_type;

   bit              grid_mirror [SIDE*SIDE*SIDE];
   cast_result_type expected_results [$];

   initial begin
      error_count = 0;
      hit_count = 0;
      ray_count = 0;
      foreach (grid_mirror[i]) grid_mirror[i] = 1'b0;
   end

   assign pending_count = expected_results.size();

   // Crossing time of axis i strictly earlier than axis j; a still axis never wins.
   function automatic bit earlier(longint unsigned ni, longint unsigned di,
                                  longint unsigned nj, longint unsigned dj);
      if (di == 0) return 1'b0;
      if (dj == 0) return 1'b1;
      return ni * dj < nj * di;
   endfunction

   function automatic cast_result_type trace_ray(logic [POS_W-1:0] s [3],
                                                 logic [POS_W-1:0] e [3]);
      cast_result_type res;
      int              vox [3];
      int              goal [3];
      int              dir [3];
      longint unsigned tnum [3];
      longint unsigned span [3];
      int              a;
      int              steps;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         vox[k] = s[k] >> FRAC;
         goal[k] = e[k] >> FRAC;
         if (e[k] >= s[k]) begin
            dir[k] = 1;
            span[k] = e[k] - s[k];
            tnum[k] = ((vox[k] + 1) << FRAC) - s[k];
         end else begin
            dir[k] = -1;
            span[k] = s[k] - e[k];
            tnum[k] = s[k] - (vox[k] << FRAC);
         end
      end
      steps = 0;
      while ((vox[0] != goal[0] || vox[1] != goal[1] || vox[2] != goal[2])
             && steps < MAX_STEPS) begin
         if (earlier(tnum[0], span[0], tnum[1], span[1]))
            a = earlier(tnum[0], span[0], tnum[2], span[2]) ? 0 : 2;
         else
            a = earlier(tnum[1], span[1], tnum[2], span[2]) ? 1 : 2;
         tnum[a] += (1 << FRAC);
         vox[a] += dir[a];
         steps++;
         if (vox[a] < 0 || vox[a] >= SIDE) return res;
         if (grid_mirror[(vox[2] * SIDE + vox[1]) * SIDE + vox[0]]) begin
            res.hit = 1'b1;
            res.x = IDX_W'(vox[0]);
            res.y = IDX_W'(vox[1]);
            res.z = IDX_W'(vox[2]);
            if (a == 0) res.nx = NRM_W'(-dir[0]);
            else if (a == 1) res.ny = NRM_W'(-dir[1]);
            else res.nz = NRM_W'(-dir[2]);
            return res;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic [POS_W-1:0] s [3];
      logic [POS_W-1:0] e [3];
      cast_result_type  want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t result item with nothing expected", $realtime);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
            if (rsp_hit_x !== want.x) report_mismatch("hit_x", rsp_hit_x, want.x);
            if (rsp_hit_y !== want.y) report_mismatch("hit_y", rsp_hit_y, want.y);
            if (rsp_hit_z !== want.z) report_mismatch("hit_z", rsp_hit_z, want.z);
            if (rsp_normal_x !== want.nx)
               report_mismatch("normal_x", rsp_normal_x, $signed(want.nx));
            if (rsp_normal_y !== want.ny)
               report_mismatch("normal_y", rsp_normal_y, $signed(want.ny));
            if (rsp_normal_z !== want.nz)
               report_mismatch("normal_z", rsp_normal_z, $signed(want.nz));
            if (want.hit) hit_count++;
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (!req_mode) begin
            grid_mirror[(req_voxel_z * SIDE + req_voxel_y) * SIDE + req_voxel_x] = req_solid;
            expected_results.push_back('0);
         end else begin
            s = '{req_start_x, req_start_y, req_start_z};
            e = '{req_end_x, req_end_y, req_end_z};
            expected_results.push_back(trace_ray(s, e));
            ray_count++;
         end
      end
   end
endmodule

### test/testbench.sv
// Top of the voxel ray traversal testbench: clock, reset, stimulus and verdict.
module testbench;
   import vrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1630;
   localparam longint CYCLE_LIMIT = 3_000_000;

   logic                    clock, reset;
   logic                    req_valid, req_ready, req_mode, req_solid;
   logic [IDX_W-1:0]        req_voxel_x, req_voxel_y, req_voxel_z;
   logic [POS_W-1:0]        req_start_x, req_start_y, req_start_z;
   logic [POS_W-1:0]        req_end_x, req_end_y, req_end_z;
   logic                    rsp_valid, rsp_ready, rsp_hit;
   logic [IDX_W-1:0]        rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   int                      error_count, pending_count, hit_count, ray_count;
   int                      item_count;
   longint                  cycle_count;
   bit                      hold_off;

   voxel_ray_traversal dut (.*);
   voxel_ray_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // Receiver: random stalls, one long hold-off while the sender keeps offering, and an always-ready stretch.
   initial begin
      rsp_ready = 1'b0;
      hold_off = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (item_count == 300 && !hold_off) begin
            hold_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (2000) @(posedge clock);
         end
         if (item_count > 800 && item_count < 1000)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_item(bit m, logic [IDX_W-1:0] vx, vy, vz, bit sol,
                            logic [POS_W-1:0] sx, sy, sz, ex, ey, ez);
      req_valid <= 1'b1;
      req_mode <= m;
      req_voxel_x <= vx;
      req_voxel_y <= vy;
      req_voxel_z <= vz;
      req_solid <= sol;
      req_start_x <= sx;
      req_start_y <= sy;
      req_start_z <= sz;
      req_end_x <= ex;
      req_end_y <= ey;
      req_end_z <= ez;
      do @(posedge clock); while (!req_ready);
      item_count++;
   endtask

   task automatic put_voxel(int x, int y, int z, bit sol);
      send_item(1'b0, IDX_W'(x), IDX_W'(y), IDX_W'(z), sol,
                POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
   endtask

   task automatic cast(int sx, int sy, int sz, int ex, int ey, int ez);
      send_item(1'b1, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), $urandom_range(0, 1),
                POS_W'(sx), POS_W'(sy), POS_W'(sz), POS_W'(ex), POS_W'(ey), POS_W'(ez));
   endtask

   function automatic int rand_pos();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32767;
         2: return $urandom_range(0, 31) << 10;
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   function automatic int near_pos(int p);
      int q;
      q = p + $signed($urandom_range(0, 8191)) - 4096;
      if (q < 0) q = 0;
      if (q > 32767) q = 32767;
      return q;
   endfunction

   initial begin
      int burst, sx, sy, sz;
      item_count = 0;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_solid = 1'b0;
      {req_voxel_x, req_voxel_y, req_voxel_z} = '0;
      {req_start_x, req_start_y, req_start_z, req_end_x, req_end_y, req_end_z} = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: same cell, empty walk, hits on every axis and sign, ties.
      cast(100, 100, 100, 900, 900, 900);
      cast(0, 0, 0, 32767, 32767, 32767);
      put_voxel(5, 0, 0, 1);
      put_voxel(0, 5, 0, 1);
      put_voxel(0, 0, 5, 1);
      put_voxel(31, 31, 31, 1);
      cast(512, 512, 512, 10 << 10, 512, 512);
      cast(512, 512, 512, 512, 10 << 10, 512);
      cast(512, 512, 512, 512, 512, 10 << 10);
      cast(10 << 10, 512, 512, 0, 512, 512);
      cast(512, 10 << 10, 512, 512, 0, 512);
      cast(512, 512, 10 << 10, 512, 512, 0);
      cast(0, 0, 0, 32767, 32767, 32767);
      cast(32767, 32767, 32767, 0, 0, 0);
      cast(30 << 10, 30 << 10, 30 << 10, 32767, 32767, 32767);
      put_voxel(31, 31, 31, 0);
      cast(32767, 32767, 32767, 0, 0, 0);
      cast(4 << 10, 512, 512, 10 << 10, 512, 512);
      cast(0, 0, 0, 6 << 10, 6 << 10, 6 << 10);
      put_voxel(5, 0, 0, 0);
      cast(512, 512, 512, 10 << 10, 512, 512);

      // Random: bursts of writes, three in four solid, and rays between random or nearby points.
      while (item_count < RANDOM_ITEMS + 21) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst; i++) begin
            if ($urandom_range(0, 2) == 0)
               put_voxel($urandom, $urandom, $urandom, $urandom_range(0, 3) != 0);
            else begin
               sx = rand_pos();
               sy = rand_pos();
               sz = rand_pos();
               if ($urandom_range(0, 1))
                  cast(sx, sy, sz, rand_pos(), rand_pos(), rand_pos());
               else
                  cast(sx, sy, sz, near_pos(sx), near_pos(sy), near_pos(sz));
            end
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("covered %0d items: %0d rays, %0d of them hits", item_count, ray_count, hit_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
